@@ design/phte_pkg.sv @@
// Shared types, constants and helpers for the pixel hex text encoder.
`timescale 1ns / 1ps
package phte_pkg;

   localparam logic [1:0] MODE_TO_GRAY    = 2'd0;
   localparam logic [1:0] MODE_GRAY       = 2'd1;
   localparam logic [1:0] MODE_COLOUR     = 2'd2;
   localparam logic [1:0] MODE_COLOUR_ALT = 2'd3;

   localparam logic CSR_ENCODE_MODE = 1'b0;
   localparam logic CSR_ROW_WIDTH   = 1'b1;

   localparam logic [5:0] LINE_GRAY   = 6'd39;
   localparam logic [5:0] LINE_COLOUR = 6'd13;

   localparam logic [17:0] GRAY_WR    = 18'd306;
   localparam logic [17:0] GRAY_WG    = 18'd601;
   localparam logic [17:0] GRAY_WB    = 18'd117;
   localparam logic [17:0] GRAY_ROUND = 18'd512;

   localparam logic [7:0] NEWLINE_CHAR = 8'd10;
   localparam logic [7:0] DIGIT_ZERO   = 8'd48;
   localparam logic [7:0] DIGIT_A      = 8'd97;

   localparam logic [2:0] HEX_GRAY   = 3'd2;
   localparam logic [2:0] HEX_COLOUR = 3'd6;

   typedef struct packed {
      logic        colour;
      logic        newline;
      logic [23:0] bytes;
   } qe_type;

   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      logic [7:0] ch;
      if (nibble < 4'd10) begin
         ch = DIGIT_ZERO + {4'b0, nibble};
      end else begin
         ch = DIGIT_A + {4'b0, nibble} - 8'd10;
      end
      return ch;
   endfunction

endpackage

@@ design/phte_front.sv @@
// Front end: configuration registers, line and row tracking, gray conversion.
`timescale 1ns / 1ps
module phte_front
   import phte_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   output logic        push_valid,
   input  logic        push_ready,
   output qe_type      push_data
);

   logic [1:0]  encode_mode_ff, encode_mode_in;
   logic [15:0] row_width_ff, row_width_in;
   logic [5:0]  line_count_ff, line_count_in;
   logic [15:0] row_index_ff, row_index_in;

   logic        s1_valid_ff, s1_valid_in;
   logic        s1_colour_ff, s1_conv_ff, s1_newline_ff;
   logic [7:0]  s1_b0_ff, s1_b1_ff, s1_b2_ff;
   logic [17:0] s1_pr_ff, s1_pg_ff, s1_pb_ff;

   logic        accept, advance;
   logic        colour, conv;
   logic [7:0]  red, green, blue, gray_level;
   logic [5:0]  limit, line_next, line_after;
   logic        nl_limit, row_end;
   logic [16:0] width, row_next;
   logic [17:0] gray_sum;

   assign red        = req_tdata[7:0];
   assign green      = req_tdata[15:8];
   assign blue       = req_tdata[23:16];
   assign gray_level = req_tdata[31:24];

   assign advance    = !s1_valid_ff || push_ready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   assign colour = (encode_mode_ff == MODE_COLOUR) || (encode_mode_ff == MODE_COLOUR_ALT);
   assign conv   = (encode_mode_ff == MODE_TO_GRAY);
   assign limit  = colour ? LINE_COLOUR : LINE_GRAY;

   assign line_next  = line_count_ff + 6'd1;
   assign nl_limit   = line_next >= limit;
   assign line_after = nl_limit ? 6'd0 : line_next;
   assign width      = (row_width_ff == 16'd0) ? 17'h10000 : {1'b0, row_width_ff};
   assign row_next   = {1'b0, row_index_ff} + 17'd1;
   assign row_end    = row_next >= width;

   always_comb begin
      encode_mode_in = encode_mode_ff;
      row_width_in   = row_width_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ENCODE_MODE: encode_mode_in = csr_wdata[1:0];
            CSR_ROW_WIDTH:   row_width_in   = csr_wdata;
            default:         ;
         endcase
      end
   end

   always_comb begin
      line_count_in = line_count_ff;
      row_index_in  = row_index_ff;
      if (accept) begin
         if (row_end) begin
            line_count_in = 6'd0;
            row_index_in  = 16'd0;
         end else begin
            line_count_in = line_after;
            row_index_in  = row_next[15:0];
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         encode_mode_ff <= MODE_TO_GRAY;
         row_width_ff   <= 16'd1;
         line_count_ff  <= 6'd0;
         row_index_ff   <= 16'd0;
         s1_valid_ff    <= 1'b0;
      end else begin
         encode_mode_ff <= encode_mode_in;
         row_width_ff   <= row_width_in;
         line_count_ff  <= line_count_in;
         row_index_ff   <= row_index_in;
         s1_valid_ff    <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_colour_ff  <= colour;
         s1_conv_ff    <= conv;
         s1_newline_ff <= nl_limit || (row_end && (line_after != 6'd0));
         s1_b0_ff      <= colour ? red : gray_level;
         s1_b1_ff      <= green;
         s1_b2_ff      <= blue;
         s1_pr_ff      <= {10'b0, red} * GRAY_WR;
         s1_pg_ff      <= {10'b0, green} * GRAY_WG;
         s1_pb_ff      <= {10'b0, blue} * GRAY_WB;
      end
   end

   assign gray_sum = s1_pr_ff + s1_pg_ff + s1_pb_ff + GRAY_ROUND;

   assign push_valid        = s1_valid_ff;
   assign push_data.colour  = s1_colour_ff;
   assign push_data.newline = s1_newline_ff;
   assign push_data.bytes   = {s1_b2_ff, s1_b1_ff, s1_conv_ff ? gray_sum[17:10] : s1_b0_ff};

endmodule

@@ design/phte_queue.sv @@
// Small FIFO of classified pixels between front and back.
`timescale 1ns / 1ps
module phte_queue
   import phte_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  qe_type push_data,
   output logic   head_valid,
   input  logic   pop,
   output qe_type head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   qe_type           slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != FULL_CNT;
   assign head_valid = count_ff != '0;
   assign head_data  = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ design/phte_back.sv @@
// Back end: walks the queue head one character per beat into the output register.
`timescale 1ns / 1ps
module phte_back
   import phte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  qe_type     head_data,
   output logic       pop,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);

   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff;
   logic       out_last_ff;

   logic       advance, emit;
   logic [2:0] hex_count;
   logic       is_nl, is_last;
   logic [3:0] nibble;
   logic [7:0] ch;

   assign advance   = !out_valid_ff || rsp_tready;
   assign emit      = advance && head_valid;
   assign hex_count = head_data.colour ? HEX_COLOUR : HEX_GRAY;
   assign is_nl     = idx_ff == hex_count;
   assign is_last   = is_nl || ((idx_ff == hex_count - 3'd1) && !head_data.newline);
   assign pop       = emit && is_last;

   always_comb begin
      case (idx_ff)
         3'd0:    nibble = head_data.bytes[7:4];
         3'd1:    nibble = head_data.bytes[3:0];
         3'd2:    nibble = head_data.bytes[15:12];
         3'd3:    nibble = head_data.bytes[11:8];
         3'd4:    nibble = head_data.bytes[23:20];
         3'd5:    nibble = head_data.bytes[19:16];
         default: nibble = 4'd0;
      endcase
      ch = is_nl ? NEWLINE_CHAR : hex_char(nibble);
   end

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = head_valid;
      end
      if (emit) begin
         idx_in = is_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_char_ff <= ch;
         out_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ design/pixel_hex_text_encoder_core.sv @@
// Top level of the pixel hex text encoder.
// Path: a pixel's beat passes through the front end's stage register, the queue and the back end's output register.
// Throughput: one character per cycle while rsp_tready holds, so 2 to 3 characters per gray pixel and
// 6 to 7 per colour pixel; the back end's single character output register sets this.
// Reset: synchronous; clears counters, queue and output, mode 0, row width 1.
`timescale 1ns / 1ps
module pixel_hex_text_encoder_core
   import phte_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red, green, blue, gray_level
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // text_char
   output logic        rsp_tlast
);

   logic   push_valid, push_ready, head_valid, pop;
   qe_type push_data, head_data;

   phte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   phte_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .head_valid (head_valid),
      .pop        (pop),
      .head_data  (head_data)
   );

   phte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ design/phte_checker.sv @@
// Port-level checks for the pixel hex text encoder, bound to the top level.
`timescale 1ns / 1ps
module phte_checker
   import phte_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled beat changed");

   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata >= DIGIT_ZERO) && (rsp_tdata <= DIGIT_ZERO + 8'd9))
                  || ((rsp_tdata >= DIGIT_A) && (rsp_tdata <= DIGIT_A + 8'd5))
                  || (rsp_tdata == NEWLINE_CHAR))
      else $error("character outside hex digits and newline");

   a_newline_ends_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata == NEWLINE_CHAR) |-> rsp_tlast)
      else $error("newline not marked last");

endmodule

bind pixel_hex_text_encoder_core phte_checker u_phte_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
